// File: hdl/pad_pkg.sv
package pad_pkg;

   // CORDIC datapath widths. Magnitudes of up to 2^15 carry 24 fraction bits,
   // and the CORDIC gain of about 1.65 on a diagonal vector stays below 2^41.
   localparam int FRAC_BITS = 24;
   localparam int CW        = 44;
   // Angle accumulator in units of 2^-16 degree, signed.
   localparam int ZW        = 26;
   // Placed angle in units of 2^-16 degree, unsigned.
   localparam int VW        = 26;
   // Width of the result field.
   localparam int AW        = 16;

   // Number of entries in the arctangent table.
   localparam int TABLE_LEN = 24;

   // atan(2^-i) in degrees times 2^16, rounded to nearest. Entries from the
   // last one onwards are zero.
   function automatic int atan_entry(int i);
      case (i)
         0:       return 2949120;
         1:       return 1740967;
         2:       return 919879;
         3:       return 466945;
         4:       return 234379;
         5:       return 117304;
         6:       return 58666;
         7:       return 29335;
         8:       return 14668;
         9:       return 7334;
         10:      return 3667;
         11:      return 1833;
         12:      return 917;
         13:      return 458;
         14:      return 229;
         15:      return 115;
         16:      return 57;
         17:      return 29;
         18:      return 14;
         19:      return 7;
         20:      return 4;
         21:      return 2;
         22:      return 1;
         default: return 0;
      endcase
   endfunction

   // Fixed angles in units of 2^-16 degree.
   localparam int DEG90_UNITS  = 90 * 65536;
   localparam int DEG180_UNITS = 180 * 65536;
   localparam int DEG360_UNITS = 360 * 65536;

   // Fixed angles in units of 1/128 degree.
   localparam int ANGLE_90   = 90 * 128;
   localparam int ANGLE_270  = 270 * 128;
   localparam int FULL_TURN  = 360 * 128;

   // Rounding from 2^-16 degree to 1/128 degree.
   localparam int ROUND_HALF  = 256;
   localparam int ROUND_SHIFT = 9;

   // CORDIC working vector and angle accumulator.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } pad_vec_type;

   // Sign information of the original request, used to place the angle.
   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_zero;
      logic dy_neg;
   } pad_side_type;

endpackage

// File: hdl/pad_prep.sv
module pad_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [15:0]   delta_x,
   input  logic signed [15:0]   delta_y,
   output logic                 out_valid,
   output pad_pkg::pad_vec_type  vec_out,
   output pad_pkg::pad_side_type side_out
);

   logic                  valid_ff;
   pad_pkg::pad_vec_type  vec_ff, vec_in;
   pad_pkg::pad_side_type side_ff, side_in;
   logic [15:0]           abs_x, abs_y;

   // Magnitudes fit 16 unsigned bits, including the most negative input.
   always_comb begin
      abs_x = delta_x[15] ? 16'(-delta_x) : 16'(delta_x);
      abs_y = delta_y[15] ? 16'(-delta_y) : 16'(delta_y);

      vec_in.x = pad_pkg::CW'({abs_x, {pad_pkg::FRAC_BITS{1'b0}}});
      vec_in.y = pad_pkg::CW'({abs_y, {pad_pkg::FRAC_BITS{1'b0}}});
      vec_in.z = '0;

      side_in.dx_zero = (delta_x == 16'sd0);
      side_in.dx_neg  = delta_x[15];
      side_in.dy_zero = (delta_y == 16'sd0);
      side_in.dy_neg  = delta_y[15];
   end

   // Valid bit of the entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // Payload of the entry stage.
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign vec_out   = vec_ff;
   assign side_out  = side_ff;

endmodule

// File: hdl/pad_stage.sv
module pad_stage #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  pad_pkg::pad_vec_type  vec_in,
   input  pad_pkg::pad_side_type side_in,
   output logic                  out_valid,
   output pad_pkg::pad_vec_type  vec_out,
   output pad_pkg::pad_side_type side_out
);

   localparam logic signed [pad_pkg::ZW-1:0] ATAN_STEP =
      pad_pkg::ZW'(pad_pkg::atan_entry(STAGE));

   logic                         valid_ff;
   pad_pkg::pad_vec_type         vec_ff, vec_nx_in;
   pad_pkg::pad_side_type        side_ff;
   logic signed [pad_pkg::CW-1:0] x_cur, y_cur, x_sh, y_sh;
   logic signed [pad_pkg::ZW-1:0] z_cur;

   // One vectoring rotation: turn the vector towards the x axis. A vector
   // already lying on the axis is left as it is.
   always_comb begin
      x_cur = vec_in.x;
      y_cur = vec_in.y;
      z_cur = vec_in.z;
      x_sh  = x_cur >>> STAGE;
      y_sh  = y_cur >>> STAGE;
      vec_nx_in = vec_in;
      if (y_cur[pad_pkg::CW-1]) begin
         vec_nx_in.x = x_cur - y_sh;
         vec_nx_in.y = y_cur + x_sh;
         vec_nx_in.z = z_cur - ATAN_STEP;
      end else if (y_cur != '0) begin
         vec_nx_in.x = x_cur + y_sh;
         vec_nx_in.y = y_cur - x_sh;
         vec_nx_in.z = z_cur + ATAN_STEP;
      end
   end

   // Valid bit of this iteration stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // Payload of this iteration stage.
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_nx_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign vec_out   = vec_ff;
   assign side_out  = side_ff;

endmodule

// File: hdl/pad_post.sv
module pad_post (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  pad_pkg::pad_vec_type          vec_in,
   input  pad_pkg::pad_side_type         side_in,
   output logic                          out_valid,
   output logic [pad_pkg::AW-1:0]        angle
);

   localparam int TW = pad_pkg::VW - 3;

   logic                         place_valid_ff, round_valid_ff;
   logic [pad_pkg::VW-1:0]       place_ff, place_in;
   pad_pkg::pad_side_type        place_side_ff;
   logic [pad_pkg::AW-1:0]       angle_ff, angle_in;
   logic signed [pad_pkg::ZW-1:0] z_cur;
   logic [TW-1:0]                theta;
   logic [pad_pkg::VW-1:0]       rounded;
   logic [pad_pkg::VW-pad_pkg::ROUND_SHIFT-1:0] coarse;

   // Clamp the first-quadrant angle to [0, 90] degrees and place it in its
   // quadrant by the signs of the request.
   always_comb begin
      z_cur = vec_in.z;
      if (z_cur[pad_pkg::ZW-1]) begin
         theta = '0;
      end else if (z_cur > pad_pkg::ZW'(pad_pkg::DEG90_UNITS)) begin
         theta = TW'(pad_pkg::DEG90_UNITS);
      end else begin
         theta = TW'(z_cur);
      end

      if (!side_in.dx_neg) begin
         place_in = side_in.dy_neg
                  ? pad_pkg::VW'(pad_pkg::DEG360_UNITS) - pad_pkg::VW'(theta)
                  : pad_pkg::VW'(theta);
      end else begin
         place_in = side_in.dy_neg
                  ? pad_pkg::VW'(pad_pkg::DEG180_UNITS) + pad_pkg::VW'(theta)
                  : pad_pkg::VW'(pad_pkg::DEG180_UNITS) - pad_pkg::VW'(theta);
      end
   end

   // Round half up to 1/128 degree, wrap a full turn to zero, and answer
   // vertical and zero vectors directly.
   always_comb begin
      rounded = place_ff + pad_pkg::VW'(pad_pkg::ROUND_HALF);
      coarse  = rounded[pad_pkg::VW-1:pad_pkg::ROUND_SHIFT];
      if (coarse >= ($bits(coarse))'(pad_pkg::FULL_TURN)) begin
         coarse = coarse - ($bits(coarse))'(pad_pkg::FULL_TURN);
      end

      if (place_side_ff.dx_zero) begin
         if (place_side_ff.dy_zero) begin
            angle_in = '0;
         end else if (place_side_ff.dy_neg) begin
            angle_in = pad_pkg::AW'(pad_pkg::ANGLE_270);
         end else begin
            angle_in = pad_pkg::AW'(pad_pkg::ANGLE_90);
         end
      end else begin
         angle_in = pad_pkg::AW'(coarse);
      end
   end

   // Valid bits of the placing and rounding stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         place_valid_ff <= 1'b0;
         round_valid_ff <= 1'b0;
      end else if (en) begin
         place_valid_ff <= in_valid;
         round_valid_ff <= place_valid_ff;
      end
   end

   // Payload of the placing and rounding stages.
   always_ff @(posedge clock) begin
      if (en) begin
         place_ff      <= place_in;
         place_side_ff <= side_in;
         angle_ff      <= angle_in;
      end
   end

   assign out_valid = round_valid_ff;
   assign angle     = angle_ff;

endmodule

// File: hdl/polar_angle_degrees.sv
// Polar angle of a signed vector (req_delta_x, req_delta_y) in units of
// 1/128 degree, from 0 up to but not including 360 degrees. The zero vector
// answers 0, a vertical vector exactly 90 or 270 degrees, and every other
// vector is resolved by CORDIC vectoring on the magnitudes followed by the
// atan2 quadrant rule. Unless the result side stalls, the pipeline takes one
// request in every cycle; it has one entry stage, one stage per CORDIC
// iteration, and two stages for placing and rounding the angle. A stall on
// the result side while a result is valid holds the whole pipeline, and
// req_stall follows it in the same cycle.
module polar_angle_degrees #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_delta_x,
   input  logic signed [15:0]  req_delta_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_angle
);

   localparam int NSTEP = (CORDIC_STEPS < pad_pkg::TABLE_LEN)
                        ? CORDIC_STEPS : pad_pkg::TABLE_LEN;

   logic                  pipe_en;
   logic                  valid_w [NSTEP+1];
   pad_pkg::pad_vec_type  vec_w   [NSTEP+1];
   pad_pkg::pad_side_type side_w  [NSTEP+1];

   // The pipeline advances unless a finished result is held at the output.
   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = !pipe_en;

   // Magnitudes and sign information.
   pad_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .delta_x   (req_delta_x),
      .delta_y   (req_delta_y),
      .out_valid (valid_w[0]),
      .vec_out   (vec_w[0]),
      .side_out  (side_w[0])
   );

   // One CORDIC iteration per stage.
   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      pad_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (valid_w[i]),
         .vec_in    (vec_w[i]),
         .side_in   (side_w[i]),
         .out_valid (valid_w[i+1]),
         .vec_out   (vec_w[i+1]),
         .side_out  (side_w[i+1])
      );
   end

   // Quadrant placement, rounding and the output register.
   pad_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (valid_w[NSTEP]),
      .vec_in    (vec_w[NSTEP]),
      .side_in   (side_w[NSTEP]),
      .out_valid (rsp_valid),
      .angle     (rsp_angle)
   );

endmodule

// File: hdl/pad_checker.sv
module pad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [15:0] req_delta_x,
   input logic [15:0] req_delta_y,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_angle
);

   // A result held by the receiver stays valid and unchanged.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle))
      else $error("result changed while stalled");

   // Every answer lies below a full turn.
   a_rsp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle < 16'd46080)
      else $error("angle out of range");

   // Requests are held back exactly while a result waits at the output.
   a_req_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the output");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind polar_angle_degrees pad_checker u_pad_checker (.*);

// File: dv/tb_polar_angle_degrees.sv
`timescale 1ns / 100ps

module tb_polar_angle_degrees;

   localparam int STEPS       = 16;
   localparam int LATENCY     = STEPS + 3;
   localparam int HOLD_CYCLES = 250;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   // One accepted request together with the angle it should produce.
   typedef struct {
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [15:0]        angle;
   } angle_request_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_delta_x;
   logic signed [15:0] req_delta_y;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_angle;

   angle_request_type expected_angles [$];
   int                error_count = 0;
   int                cycle_count = 0;
   stall_mode_type    stall_mode  = STALL_NONE;
   int                stall_phase = 0;
   logic              stall_hold  = 1'b0;
   bit                sender_idles = 1'b0;
   int                burst_left   = 0;
   event              hold_kick;

   polar_angle_degrees #(
      .CORDIC_STEPS (STEPS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_delta_x (req_delta_x),
      .req_delta_y (req_delta_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_angle   (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Polar angle in 1/128 degree, computed by CORDIC vectoring on the
   // magnitudes and placed in its quadrant by the atan2 rule.
   function automatic logic [15:0] polar_angle_of(logic signed [15:0] dx,
                                                  logic signed [15:0] dy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint v;
      longint a;
      if (dx == 0) begin
         if (dy == 0) return 16'd0;
         return (dy > 0) ? 16'(pad_pkg::ANGLE_90) : 16'(pad_pkg::ANGLE_270);
      end
      x = (dx < 0) ? -longint'(dx) : longint'(dx);
      y = (dy < 0) ? -longint'(dy) : longint'(dy);
      x = x <<< pad_pkg::FRAC_BITS;
      y = y <<< pad_pkg::FRAC_BITS;
      z = 0;
      for (int i = 0; i < STEPS && i < pad_pkg::TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         // Once the residual is exactly zero the vector is left alone.
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + pad_pkg::atan_entry(i);
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - pad_pkg::atan_entry(i);
         end
      end
      if (z < 0) z = 0;
      if (z > pad_pkg::DEG90_UNITS) z = pad_pkg::DEG90_UNITS;
      if (dx > 0) begin
         v = (dy >= 0) ? z : longint'(pad_pkg::DEG360_UNITS) - z;
      end else begin
         v = (dy >= 0) ? longint'(pad_pkg::DEG180_UNITS) - z
                       : longint'(pad_pkg::DEG180_UNITS) + z;
      end
      a = (v + pad_pkg::ROUND_HALF) >>> pad_pkg::ROUND_SHIFT;
      // A result that rounds up to a full turn wraps to zero.
      if (a >= pad_pkg::FULL_TURN) a = a - pad_pkg::FULL_TURN;
      return a[15:0];
   endfunction

   task automatic report_mismatch(string what, angle_request_type item,
                                  logic [15:0] got);
      $display("mismatch (%s) dx=%0d dy=%0d expected %0d got %0d at cycle %0d",
               what, item.dx, item.dy, item.angle, got, cycle_count);
      error_count++;
   endtask

   // Appends one accepted request to the queue of expected results.
   task automatic remember_request(angle_request_type item);
      expected_angles = {expected_angles, item};
   endtask

   // Result check and request capture, both sampled on the same edge.
   always @(posedge clock) begin
      angle_request_type item;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               item.dx    = 'x;
               item.dy    = 'x;
               item.angle = 'x;
               report_mismatch("unexpected result", item, rsp_angle);
            end else begin
               item = expected_angles.pop_front();
               if (rsp_angle !== item.angle) report_mismatch("angle", item, rsp_angle);
            end
         end
         if (req_valid && !req_stall) begin
            item.dx    = req_delta_x;
            item.dy    = req_delta_y;
            item.angle = polar_angle_of(req_delta_x, req_delta_y);
            remember_request(item);
         end
         // Receiver stall, on a pattern of its own or at random, plus the long hold-off.
         stall_phase <= (stall_phase + 1) % 7;
         case (stall_mode)
            STALL_RANDOM: begin
               rsp_stall <= stall_hold || ($urandom_range(0, 99) < 35);
            end
            STALL_PATTERN: begin
               rsp_stall <= stall_hold || (stall_phase inside {1, 2, 5});
            end
            default: begin
               rsp_stall <= stall_hold;
            end
         endcase
      end
   end

   // Long receiver hold-off, counted here so that the sender runs on freely.
   initial begin
      forever begin
         @(hold_kick);
         @(posedge clock);
         stall_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         stall_hold <= 1'b0;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offers one request and waits for the edge that accepts it. Valid stays
   // high afterwards unless the burst has run out; then the gap is idled first.
   task automatic send_vector(logic signed [15:0] dx, logic signed [15:0] dy);
      req_valid   <= 1'b1;
      req_delta_x <= dx;
      req_delta_y <= dy;
      do @(posedge clock); while (req_stall);
      if (sender_idles) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops offering and waits until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   // A random offset, weighted towards extremes, small values and zero.
   function automatic logic signed [15:0] random_offset();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 16)) - 16'sd8;
         1: begin
            case ($urandom_range(0, 5))
               0: return -16'sd32768;
               1: return -16'sd32767;
               2: return 16'sd32767;
               3: return 16'sd1;
               4: return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_random_vectors(int count);
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         dx   = random_offset();
         dy   = random_offset();
         pick = $urandom_range(0, 15);
         // Some requests lie on an axis, some on or near a diagonal.
         if (pick == 0) dx = 16'sd0;
         else if (pick == 1) dy = 16'sd0;
         else if (pick == 2) dy = dx;
         else if (pick == 3) dy = -dx + 16'($urandom_range(0, 2)) - 16'sd1;
         send_vector(dx, dy);
      end
   endtask

   // Axes, quadrant corners, extremes, the residual-zero diagonal and the
   // vector just below the positive x axis that wraps to zero.
   task automatic test_axes_and_extremes();
      stall_mode   = STALL_NONE;
      sender_idles = 1'b0;
      send_vector(16'sd0, 16'sd0);
      send_vector(16'sd0, 16'sd1);
      send_vector(16'sd0, -16'sd1);
      send_vector(16'sd0, 16'sd32767);
      send_vector(16'sd0, -16'sd32768);
      send_vector(16'sd1, 16'sd0);
      send_vector(-16'sd1, 16'sd0);
      send_vector(16'sd32767, 16'sd0);
      send_vector(-16'sd32768, 16'sd0);
      send_vector(16'sd1, 16'sd1);
      send_vector(-16'sd1, 16'sd1);
      send_vector(-16'sd1, -16'sd1);
      send_vector(16'sd1, -16'sd1);
      send_vector(16'sd32767, 16'sd32767);
      send_vector(-16'sd32768, -16'sd32768);
      send_vector(-16'sd32768, 16'sd32767);
      send_vector(16'sd32767, -16'sd32768);
      send_vector(16'sd1, 16'sd32767);
      send_vector(16'sd32767, 16'sd1);
      send_vector(-16'sd32768, 16'sd1);
      send_vector(-16'sd1, -16'sd32768);
      send_vector(16'sd32767, -16'sd1);
      send_vector(16'sd3, 16'sd4);
      send_vector(-16'sd3, -16'sd4);
      drain_results();
   endtask

   // Back-to-back requests with no idling on either side.
   task automatic test_back_to_back();
      stall_mode   = STALL_NONE;
      sender_idles = 1'b0;
      send_random_vectors(150);
      drain_results();
   endtask

   // Bursty sender against a receiver that stalls at random.
   task automatic test_bursty_traffic();
      stall_mode   = STALL_RANDOM;
      sender_idles = 1'b1;
      burst_left   = $urandom_range(1, 12);
      send_random_vectors(250);
      drain_results();
   endtask

   // Steady sender against a receiver stalling on a fixed pattern.
   task automatic test_patterned_stall();
      stall_mode   = STALL_PATTERN;
      sender_idles = 1'b0;
      send_random_vectors(120);
      drain_results();
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the pipeline fills and the input side stalls.
   task automatic test_backpressure_fill();
      stall_mode   = STALL_NONE;
      sender_idles = 1'b0;
      -> hold_kick;
      send_random_vectors(80);
      drain_results();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_delta_x <= '0;
      req_delta_y <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_axes_and_extremes();
      test_back_to_back();
      test_bursty_traffic();
      test_patterned_stall();
      test_backpressure_fill();

      // Allow any stray result to surface before the verdict.
      stall_mode = STALL_NONE;
      repeat (LATENCY + 8) @(posedge clock);
      if (expected_angles.size() != 0) begin
         $display("%0d expected results never arrived", expected_angles.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
